// ===== rtl/lsbfs_pkg.sv =====
// Shared types and constants for the level-synchronous BFS unit.
package lsbfs_pkg;

  // Fixed field widths of the item and result beats
  localparam int OpW      = 2;
  localparam int NodeW    = 10;
  localparam int FirstW   = 13;
  localparam int DegW     = 14;
  localparam int SlotW    = 13;
  localparam int CountW   = 11;
  localparam int DistW    = 10;
  // Edge cursor: first_edge plus out_degree always fits here
  localparam int CursorW  = 15;

  // Item operation codes
  localparam logic [OpW-1:0] OP_LOAD_NODE = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_EDGE = 2'd1;
  localparam logic [OpW-1:0] OP_START     = 2'd2;

  // Result status codes
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_BAD_SRC   = 1'b1;

  // Search sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_FREAD,
    S_FWAIT,
    S_NWAIT,
    S_EREAD,
    S_EWAIT,
    S_VCHK,
    S_DONE
  } bfs_state_t;

endpackage

// ===== rtl/lsbfs_graph_mem.sv =====
// Adjacency storage: node table (first edge, degree) and edge target memory.
module lsbfs_graph_mem
  import lsbfs_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192,
  localparam int NW = $clog2(MAX_NODES),
  localparam int EW = $clog2(MAX_EDGES)
) (
  input  logic              clk,
  input  logic              node_we,
  input  logic [NW-1:0]     node_waddr,
  input  logic [FirstW-1:0] node_wfirst,
  input  logic [DegW-1:0]   node_wdeg,
  input  logic [NW-1:0]     node_raddr,
  output logic [FirstW-1:0] node_rfirst,
  output logic [DegW-1:0]   node_rdeg,
  input  logic              edge_we,
  input  logic [EW-1:0]     edge_waddr,
  input  logic [NodeW-1:0]  edge_wdata,
  input  logic [EW-1:0]     edge_raddr,
  output logic [NodeW-1:0]  edge_rdata
);

  logic [FirstW+DegW-1:0] node_mem [MAX_NODES];
  logic [NodeW-1:0]       edge_mem [MAX_EDGES];
  logic [FirstW+DegW-1:0] node_rword;

  // Node table: one write, one registered read
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= {node_wfirst, node_wdeg};
    end
    node_rword <= node_mem[node_raddr];
  end

  assign node_rfirst = node_rword[FirstW+DegW-1:DegW];
  assign node_rdeg   = node_rword[DegW-1:0];

  // Edge targets: one write, one registered read
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

endmodule

// ===== rtl/lsbfs_walk_mem.sv =====
// Search state: visited marks and the two frontier buffers.
module lsbfs_walk_mem
  import lsbfs_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  localparam int NW = $clog2(MAX_NODES)
) (
  input  logic          clk,
  input  logic          vis_we,
  input  logic [NW-1:0] vis_waddr,
  input  logic          vis_wdata,
  input  logic [NW-1:0] vis_raddr,
  output logic          vis_rdata,
  input  logic          fr_we,
  input  logic          fr_wsel,
  input  logic [NW-1:0] fr_waddr,
  input  logic [NW-1:0] fr_wdata,
  input  logic          fr_rsel,
  input  logic [NW-1:0] fr_raddr,
  output logic [NW-1:0] fr_rdata
);

  logic          vis_mem [MAX_NODES];
  logic [NW-1:0] fra_mem [MAX_NODES];
  logic [NW-1:0] frb_mem [MAX_NODES];
  logic [NW-1:0] fra_q;
  logic [NW-1:0] frb_q;
  logic          rsel_q;

  // Visited marks
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[vis_raddr];
  end

  // Frontier buffers; select picks which one a port addresses
  always_ff @(posedge clk) begin
    if (fr_we && !fr_wsel) begin
      fra_mem[fr_waddr] <= fr_wdata;
    end
    fra_q <= fra_mem[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (fr_we && fr_wsel) begin
      frb_mem[fr_waddr] <= fr_wdata;
    end
    frb_q  <= frb_mem[fr_raddr];
    rsel_q <= fr_rsel;
  end

  assign fr_rdata = rsel_q ? frb_q : fra_q;

endmodule

// ===== rtl/level_sync_bfs_distances_unit.sv =====
// Level-synchronous BFS unit: graph loading, search sequencer and result beat.
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid / in_stall    | op node first_edge fanout edge_slot neighbour
//   out     | source    | out_valid / out_stall  | status reachable deepest_hop
//   cfg     | sink      | cfg_wr_en              | cfg_wr_data (node_count)
//
// Load beats are taken while idle. A start beat first clears the visited marks of
// the active nodes, then walks level by level, reading each frontier node and then
// its edges one at a time through the single read port of each memory in the walk.
// rst is synchronous and returns node_count to 1 and the sequencer to idle.
// in_stall is high while a search runs; a result waiting on out_stall still lets
// load beats in, and a finished search holds until the output register frees.
module level_sync_bfs_distances_unit
  import lsbfs_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CountW-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OpW-1:0]    op,
  input  logic [NodeW-1:0]  node,
  input  logic [FirstW-1:0] first_edge,
  input  logic [DegW-1:0]   fanout,
  input  logic [SlotW-1:0]  edge_slot,
  input  logic [NodeW-1:0]  neighbour,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [CountW-1:0] reachable,
  output logic [DistW-1:0]  deepest_hop
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);

  bfs_state_t state, state_next;

  logic [CountW-1:0]  node_count;
  logic [CountW-1:0]  n_act;
  logic [CountW-1:0]  n_eff;
  logic [NodeW-1:0]   src;
  logic [CountW-1:0]  cnt;
  logic               sel;
  logic [CountW-1:0]  cur_len;
  logic [CountW-1:0]  next_len;
  logic [CountW-1:0]  fidx;
  logic [CountW-1:0]  level;
  logic [CountW-1:0]  reach;
  logic [CountW-1:0]  maxd;
  logic [CursorW-1:0] slot;
  logic [CursorW-1:0] slot_end;
  logic [NodeW-1:0]   nb;

  logic               accept;
  logic               node_ok;
  logic               edge_ok;
  logic               out_free;

  logic               node_we;
  logic [NW-1:0]      node_raddr;
  logic [FirstW-1:0]  node_rfirst;
  logic [DegW-1:0]    node_rdeg;
  logic               edge_we;
  logic [EW-1:0]      edge_raddr;
  logic [NodeW-1:0]   edge_rdata;
  logic               vis_we;
  logic [NW-1:0]      vis_waddr;
  logic               vis_wdata;
  logic [NW-1:0]      vis_raddr;
  logic               vis_rdata;
  logic               fr_we;
  logic               fr_wsel;
  logic [NW-1:0]      fr_waddr;
  logic [NW-1:0]      fr_wdata;
  logic [NW-1:0]      fr_raddr;
  logic [NW-1:0]      fr_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign n_eff    = (32'(node_count) > MAX_NODES) ? CountW'(MAX_NODES) : node_count;
  assign node_ok  = (32'(node) < MAX_NODES) &&
                    ((32'(first_edge) + 32'(fanout)) <= MAX_EDGES);
  assign edge_ok  = 32'(edge_slot) < MAX_EDGES;
  assign node_we  = accept && (op == OP_LOAD_NODE) && node_ok;
  assign edge_we  = accept && (op == OP_LOAD_EDGE) && edge_ok;

  lsbfs_graph_mem #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_graph (
    .clk         (clk),
    .node_we     (node_we),
    .node_waddr  (NW'(node)),
    .node_wfirst (first_edge),
    .node_wdeg   (fanout),
    .node_raddr  (node_raddr),
    .node_rfirst (node_rfirst),
    .node_rdeg   (node_rdeg),
    .edge_we     (edge_we),
    .edge_waddr  (EW'(edge_slot)),
    .edge_wdata  (neighbour),
    .edge_raddr  (edge_raddr),
    .edge_rdata  (edge_rdata)
  );

  lsbfs_walk_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_walk (
    .clk       (clk),
    .vis_we    (vis_we),
    .vis_waddr (vis_waddr),
    .vis_wdata (vis_wdata),
    .vis_raddr (vis_raddr),
    .vis_rdata (vis_rdata),
    .fr_we     (fr_we),
    .fr_wsel   (fr_wsel),
    .fr_waddr  (fr_waddr),
    .fr_wdata  (fr_wdata),
    .fr_rsel   (sel),
    .fr_raddr  (fr_raddr),
    .fr_rdata  (fr_rdata)
  );

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CountW'(1);
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    node_raddr = NW'(fr_rdata);
    edge_raddr = EW'(slot);
    vis_we     = 1'b0;
    vis_waddr  = NW'(cnt);
    vis_wdata  = 1'b0;
    vis_raddr  = NW'(edge_rdata);
    fr_we      = 1'b0;
    fr_wsel    = sel;
    fr_waddr   = NW'(next_len);
    fr_wdata   = NW'(nb);
    fr_raddr   = NW'(fidx);
    case (state)
      S_IDLE: begin
        if (accept && op == OP_START) begin
          state_next = ({1'b0, node} >= n_eff) ? S_DONE : S_CLEAR;
        end
      end
      S_CLEAR: begin
        vis_we = 1'b1;
        if (cnt == n_act - CountW'(1)) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        vis_we    = 1'b1;
        vis_waddr = NW'(src);
        vis_wdata = 1'b1;
        fr_we     = 1'b1;
        fr_wsel   = 1'b0;
        fr_waddr  = '0;
        fr_wdata  = NW'(src);
        state_next = S_FREAD;
      end
      S_FREAD: begin
        if (fidx == cur_len) begin
          if (next_len == '0) begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_FWAIT;
        end
      end
      S_FWAIT: begin
        state_next = S_NWAIT;
      end
      S_NWAIT: begin
        state_next = S_EREAD;
      end
      S_EREAD: begin
        if (slot >= slot_end || 32'(slot) >= MAX_EDGES) begin
          state_next = S_FREAD;
        end else begin
          state_next = S_EWAIT;
        end
      end
      S_EWAIT: begin
        state_next = ({1'b0, edge_rdata} >= n_act) ? S_EREAD : S_VCHK;
      end
      S_VCHK: begin
        if (!vis_rdata) begin
          vis_we    = 1'b1;
          vis_waddr = NW'(nb);
          vis_wdata = 1'b1;
          fr_we     = 1'b1;
          fr_wsel   = !sel;
        end
        state_next = S_EREAD;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Search datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        src   <= node;
        n_act <= n_eff;
        cnt   <= '0;
        reach <= '0;
        maxd  <= '0;
      end
      S_CLEAR: begin
        cnt <= cnt + CountW'(1);
      end
      S_SEED: begin
        sel      <= 1'b0;
        cur_len  <= CountW'(1);
        next_len <= '0;
        fidx     <= '0;
        level    <= '0;
        reach    <= CountW'(1);
        maxd     <= '0;
      end
      S_FREAD: begin
        // Swap frontiers at the end of a level
        if (fidx == cur_len && next_len != '0) begin
          sel      <= !sel;
          cur_len  <= next_len;
          next_len <= '0;
          fidx     <= '0;
          level    <= level + CountW'(1);
          maxd     <= level + CountW'(1);
        end
      end
      S_NWAIT: begin
        slot     <= CursorW'(node_rfirst);
        slot_end <= CursorW'(node_rfirst) + CursorW'(node_rdeg);
        fidx     <= fidx + CountW'(1);
      end
      S_EREAD: begin
        slot <= slot + CursorW'(1);
      end
      S_EWAIT: begin
        nb <= edge_rdata;
      end
      S_VCHK: begin
        if (!vis_rdata) begin
          next_len <= next_len + CountW'(1);
          reach    <= reach + CountW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: drop a taken beat, load a finished result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= (reach == '0) ? ST_BAD_SRC : ST_DONE;
      reachable   <= reach;
      deepest_hop <= maxd[DistW-1:0];
    end
  end

endmodule
